### hdl/timer_expiry_queue_defines.svh
// Assertion macros used by the checker file.
`ifndef TIMER_EXPIRY_QUEUE_DEFINES_SVH
`define TIMER_EXPIRY_QUEUE_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define TEQ_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define TEQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

### hdl/teq_pkg.sv
// ----------------------------------------------------------------------------
// teq_pkg
// Types and constants shared by the timer expiry queue modules.
// ----------------------------------------------------------------------------
package teq_pkg;

    localparam int unsigned TIMER_SLOTS = 16;

    typedef enum logic [1:0] {
        REQ_SCHEDULE = 2'd0,
        REQ_CANCEL   = 2'd1,
        REQ_TICK     = 2'd2,
        REQ_NONE     = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        EV_SCHEDULED = 2'd0,
        EV_CANCELED  = 2'd1,
        EV_EXPIRED   = 2'd2,
        EV_DONE      = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT,
        ST_RETIRE,
        ST_RESULT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture request fields
        logic scan_clr;  // restart scan index and best candidate
        logic scan_step; // examine one slot
        logic emit;      // present best slot as expired transaction
        logic retire;    // retire one due slot
        logic fin;       // present final result for request
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_end;  // the slot being examined is the last one
        logic found;     // a candidate was found in this pass
        logic out_busy;  // output register holds an untaken transaction
    } sts_t;

endpackage

### hdl/timer_expiry_queue.sv
// Schedule and cancel: the result follows one scan of the table and the result state;
// the next request is taken once the sequencer is back in idle.
// Tick with k due timers: k+1 scans of the table, each but the last followed by an emit,
// then a retire pass and the result state, as the single shared compare unit walks the table.
// Each result waits while the output register still holds an untaken transaction.
// Reset (aresetn low, synchronous) empties the table and restarts ids at 1.
// ----------------------------------------------------------------------------
// timer_expiry_queue
// Table of software timers with ordered expiry reporting.
// ----------------------------------------------------------------------------
module timer_expiry_queue #(
    parameter int unsigned TIMER_SLOTS = teq_pkg::TIMER_SLOTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [63:0] s_now_time,
    input  logic [63:0] s_expire_at,
    input  logic [31:0] s_repeat_interval,
    input  logic [31:0] s_cancel_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_kind,
    output logic        m_ok,
    output logic [31:0] m_timer_ident,
    output logic [63:0] m_expiry_time,
    output logic [63:0] m_set_time,
    output logic        m_last
);

    teq_pkg::cmd_t cmd;
    teq_pkg::sts_t sts;

    // Sequencer.
    teq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .req     (teq_pkg::req_t'(s_req_type)),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Table and output register.
    teq_datapath #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .s_req_type        (s_req_type),
        .s_now_time        (s_now_time),
        .s_expire_at       (s_expire_at),
        .s_repeat_interval (s_repeat_interval),
        .s_cancel_id       (s_cancel_id),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_event_kind      (m_event_kind),
        .m_ok              (m_ok),
        .m_timer_ident     (m_timer_ident),
        .m_expiry_time     (m_expiry_time),
        .m_set_time        (m_set_time),
        .m_last            (m_last)
    );

endmodule

### hdl/teq_ctrl.sv
// ----------------------------------------------------------------------------
// teq_ctrl
// Sequencer that walks the slot table for each request.
// ----------------------------------------------------------------------------
module teq_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  teq_pkg::req_t   req,
    input  teq_pkg::sts_t   sts,
    output teq_pkg::cmd_t   cmd
);

    teq_pkg::state_t state_reg, state_next;
    teq_pkg::req_t   req_reg, req_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= teq_pkg::ST_IDLE;
            req_reg   <= teq_pkg::REQ_NONE;
        end else begin
            state_reg <= state_next;
            req_reg   <= req_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            teq_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load     = 1'b1;
                    cmd.scan_clr = 1'b1;
                    req_next     = req;
                    if (req != teq_pkg::REQ_NONE) begin
                        state_next = teq_pkg::ST_SCAN;
                    end
                end
            end
            teq_pkg::ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_end) begin
                    if (req_reg == teq_pkg::REQ_TICK) begin
                        state_next = teq_pkg::ST_EMIT;
                    end else begin
                        state_next = teq_pkg::ST_RESULT;
                    end
                end
            end
            teq_pkg::ST_EMIT: begin
                // Either send the minimum found, or move on to retiring.
                if (!sts.found) begin
                    cmd.scan_clr = 1'b1;
                    state_next   = teq_pkg::ST_RETIRE;
                end else if (!sts.out_busy) begin
                    cmd.emit     = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = teq_pkg::ST_SCAN;
                end
            end
            teq_pkg::ST_RETIRE: begin
                cmd.retire = 1'b1;
                if (sts.scan_end) begin
                    state_next = teq_pkg::ST_RESULT;
                end
            end
            teq_pkg::ST_RESULT: begin
                if (!sts.out_busy) begin
                    cmd.fin    = 1'b1;
                    state_next = teq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = teq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/teq_datapath.sv
// ----------------------------------------------------------------------------
// teq_datapath
// Slot table, scan comparator, id counter and output register.
// ----------------------------------------------------------------------------
module teq_datapath #(
    parameter int unsigned TIMER_SLOTS = teq_pkg::TIMER_SLOTS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  teq_pkg::cmd_t cmd,
    output teq_pkg::sts_t sts,
    input  logic [1:0]    s_req_type,
    input  logic [63:0]   s_now_time,
    input  logic [63:0]   s_expire_at,
    input  logic [31:0]   s_repeat_interval,
    input  logic [31:0]   s_cancel_id,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [1:0]    m_event_kind,
    output logic          m_ok,
    output logic [31:0]   m_timer_ident,
    output logic [63:0]   m_expiry_time,
    output logic [63:0]   m_set_time,
    output logic          m_last
);

    localparam int unsigned IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    // Slot storage; only valid and flag bits are reset.
    logic [TIMER_SLOTS-1:0] valid_reg;
    logic [TIMER_SLOTS-1:0] due_reg;
    logic [TIMER_SLOTS-1:0] sent_reg;
    logic [31:0]            id_mem  [TIMER_SLOTS];
    logic [63:0]            exp_mem [TIMER_SLOTS];
    logic [31:0]            per_mem [TIMER_SLOTS];
    logic [63:0]            set_mem [TIMER_SLOTS];

    // Captured request.
    logic [1:0]  req_reg;
    logic [63:0] now_reg;
    logic [63:0] expat_reg;
    logic [31:0] per_reg;
    logic [31:0] cid_reg;
    logic [31:0] ident_reg;

    // Scan state.
    logic [IW-1:0] idx_reg;
    logic          found_reg;
    logic [IW-1:0] best_reg;
    logic [63:0]   best_exp_reg;
    logic [31:0]   best_id_reg;

    // Output register.
    logic        oval_reg;
    logic [1:0]  okind_reg;
    logic        ook_reg;
    logic [31:0] oid_reg;
    logic [63:0] oexp_reg;
    logic [63:0] oset_reg;
    logic        olast_reg;

    logic        cur_valid;
    logic [31:0] cur_id;
    logic [63:0] cur_exp;
    logic        cur_due;
    logic        better;
    logic        cand;
    logic        scan_end;

    assign cur_valid = valid_reg[idx_reg];
    assign cur_id    = id_mem[idx_reg];
    assign cur_exp   = exp_mem[idx_reg];
    assign cur_due   = cur_valid && (cur_exp <= now_reg);
    assign scan_end  = (idx_reg == IW'(TIMER_SLOTS - 1));
    // Equal expiry and id keeps the earlier slot, matching index order.
    assign better    = (cur_exp < best_exp_reg) ||
                       ((cur_exp == best_exp_reg) && (cur_id < best_id_reg));

    // Candidate test per request kind during a scan step.
    always_comb begin
        unique case (req_reg)
            teq_pkg::REQ_SCHEDULE: cand = !cur_valid;
            teq_pkg::REQ_CANCEL:   cand = cur_valid && (cur_id == cid_reg);
            default:               cand = due_reg[idx_reg] && !sent_reg[idx_reg]
                                          && (!found_reg || better);
        endcase
    end

    assign sts.scan_end = scan_end;
    assign sts.found    = found_reg;
    assign sts.out_busy = oval_reg;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            due_reg   <= '0;
            sent_reg  <= '0;
            ident_reg <= '0;
            found_reg <= 1'b0;
            idx_reg   <= '0;
            oval_reg  <= 1'b0;
        end else begin
            if (cmd.load) begin
                sent_reg <= '0;
                due_reg  <= '0;
            end
            if (cmd.scan_clr) begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.scan_step) begin
                idx_reg <= scan_end ? '0 : idx_reg + 1'b1;
                if (req_reg == teq_pkg::REQ_TICK) begin
                    // Due set is latched on the first pass only.
                    if (sent_reg == '0) begin
                        due_reg[idx_reg] <= cur_due;
                    end
                    if (((sent_reg == '0) ? cur_due : due_reg[idx_reg])
                        && !sent_reg[idx_reg] && (!found_reg || better)) begin
                        found_reg <= 1'b1;
                    end
                end else if (cand && !found_reg) begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.emit) begin
                sent_reg[best_reg] <= 1'b1;
            end
            if (cmd.retire) begin
                idx_reg <= scan_end ? '0 : idx_reg + 1'b1;
                if (due_reg[idx_reg] && per_mem[idx_reg] == '0) begin
                    valid_reg[idx_reg] <= 1'b0;
                end
            end
            if (cmd.fin) begin
                if (req_reg == teq_pkg::REQ_SCHEDULE && found_reg) begin
                    valid_reg[best_reg] <= 1'b1;
                    ident_reg           <= ident_reg + 32'd1;
                end
                if (req_reg == teq_pkg::REQ_CANCEL && found_reg) begin
                    valid_reg[best_reg] <= 1'b0;
                end
            end
            if (cmd.emit || cmd.fin) begin
                oval_reg <= 1'b1;
            end else if (m_ready) begin
                oval_reg <= 1'b0;
            end
        end
    end

    // Payload registers and slot memories.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg   <= s_req_type;
            now_reg   <= s_now_time;
            expat_reg <= s_expire_at;
            per_reg   <= s_repeat_interval;
            cid_reg   <= s_cancel_id;
        end
        if (cmd.scan_step) begin
            if (req_reg == teq_pkg::REQ_TICK) begin
                if (((sent_reg == '0) ? cur_due : due_reg[idx_reg])
                    && !sent_reg[idx_reg] && (!found_reg || better)) begin
                    best_reg     <= idx_reg;
                    best_exp_reg <= cur_exp;
                    best_id_reg  <= cur_id;
                end
            end else if (cand && !found_reg) begin
                best_reg <= idx_reg;
            end
        end
        if (cmd.retire && due_reg[idx_reg]) begin
            exp_mem[idx_reg] <= cur_exp + {32'd0, per_mem[idx_reg]};
            set_mem[idx_reg] <= now_reg;
        end
        if (cmd.fin && req_reg == teq_pkg::REQ_SCHEDULE && found_reg) begin
            id_mem[best_reg]  <= ident_reg + 32'd1;
            exp_mem[best_reg] <= expat_reg;
            per_mem[best_reg] <= per_reg;
            set_mem[best_reg] <= now_reg;
        end
        if (cmd.emit) begin
            okind_reg <= teq_pkg::EV_EXPIRED;
            ook_reg   <= 1'b1;
            oid_reg   <= id_mem[best_reg];
            oexp_reg  <= exp_mem[best_reg];
            oset_reg  <= set_mem[best_reg];
            olast_reg <= 1'b0;
        end else if (cmd.fin) begin
            oexp_reg  <= '0;
            oset_reg  <= '0;
            olast_reg <= 1'b1;
            unique case (req_reg)
                teq_pkg::REQ_SCHEDULE: begin
                    okind_reg <= teq_pkg::EV_SCHEDULED;
                    ook_reg   <= found_reg;
                    oid_reg   <= found_reg ? ident_reg + 32'd1 : 32'd0;
                end
                teq_pkg::REQ_CANCEL: begin
                    okind_reg <= teq_pkg::EV_CANCELED;
                    ook_reg   <= found_reg;
                    oid_reg   <= cid_reg;
                end
                default: begin
                    okind_reg <= teq_pkg::EV_DONE;
                    ook_reg   <= 1'b1;
                    oid_reg   <= '0;
                end
            endcase
        end
    end

    assign m_valid       = oval_reg;
    assign m_event_kind  = okind_reg;
    assign m_ok          = ook_reg;
    assign m_timer_ident = oid_reg;
    assign m_expiry_time = oexp_reg;
    assign m_set_time    = oset_reg;
    assign m_last        = olast_reg;

endmodule

### hdl/teq_checker.sv
// ----------------------------------------------------------------------------
// teq_checker
// Port-level checks for the timer expiry queue.
// ----------------------------------------------------------------------------
`include "timer_expiry_queue_defines.svh"

module teq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_req_type,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_event_kind,
    input logic        m_ok,
    input logic [31:0] m_timer_ident,
    input logic        m_last
);

    // A stalled result transaction keeps its kind.
    `TEQ_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_event_kind), "result dropped while stalled")
    // Expired results are never last; the other kinds always are.
    `TEQ_ASSERT_IMPL(a_last, aclk, aresetn, m_valid, m_last == (m_event_kind != teq_pkg::EV_EXPIRED), "last flag wrong")
    // Done results carry ok and no id.
    `TEQ_ASSERT_IMPL(a_done, aclk, aresetn, m_valid && m_event_kind == teq_pkg::EV_DONE, m_ok && m_timer_ident == 32'd0, "done result malformed")
    // No new request is taken in the cycle after a known request is taken.
    `TEQ_ASSERT_NEXT(a_seq, aclk, aresetn, s_valid && s_ready && (s_req_type != teq_pkg::REQ_NONE), !s_ready, "request overlap")

endmodule

bind timer_expiry_queue teq_checker u_teq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_req_type    (s_req_type),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_event_kind  (m_event_kind),
    .m_ok          (m_ok),
    .m_timer_ident (m_timer_ident),
    .m_last        (m_last)
);

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Timer expiry queue testbench
// Drives schedule, cancel, tick and unknown requests into the timer table and
// checks every result transaction against a predictor that keeps its own copy
// of the table. A directed stimulus table comes first, then random traffic.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOTS = 16;
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = teq_pkg::REQ_NONE;
    logic [63:0] s_now_time = '0;
    logic [63:0] s_expire_at = '0;
    logic [31:0] s_repeat_interval = '0;
    logic [31:0] s_cancel_id = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_event_kind;
    logic        m_ok;
    logic [31:0] m_timer_ident;
    logic [63:0] m_expiry_time;
    logic [63:0] m_set_time;
    logic        m_last;

    typedef struct packed {
        logic [1:0]  kind;
        logic        ok;
        logic [31:0] ident;
        logic [63:0] expiry;
        logic [63:0] set_at;
        logic        last;
    } event_rec_t;

    typedef struct {
        teq_pkg::req_t req;
        logic [63:0]   now;
        logic [63:0]   exp_at;
        logic [31:0]   period;
        logic [31:0]   cid;
        bit            typed;  // expected first result typed in below
        event_rec_t    first;
    } stim_row_t;

    timer_expiry_queue u_top (.*);

    // Clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor copy of the timer table.
    bit          tbl_valid [NSLOTS];
    logic [31:0] tbl_id    [NSLOTS];
    logic [63:0] tbl_exp   [NSLOTS];
    logic [31:0] tbl_per   [NSLOTS];
    logic [63:0] tbl_set   [NSLOTS];
    logic [31:0] last_ident;

    event_rec_t pending_events[$];
    int  mismatches = 0;
    int  events_seen = 0;
    int  expiries_seen = 0;
    int  cycles = 0;
    int  send_idle_pct = 20;
    int  recv_idle_pct = 50;
    int  hold_off = 0;

    function automatic event_rec_t mk(logic [1:0] k, logic o, logic [31:0] id,
                                      logic [63:0] e, logic [63:0] s, logic l);
        event_rec_t r;
        r.kind = k; r.ok = o; r.ident = id; r.expiry = e; r.set_at = s; r.last = l;
        return r;
    endfunction

    function automatic bit orders_first(int a, int b);
        if (tbl_exp[a] != tbl_exp[b]) return tbl_exp[a] < tbl_exp[b];
        if (tbl_id[a] != tbl_id[b]) return tbl_id[a] < tbl_id[b];
        return a < b;
    endfunction

    // Append one expected result at the tail of the queue.
    task automatic expect_event(event_rec_t r);
        pending_events.insert(pending_events.size(), r);
    endtask

    // Apply one request to the table and queue the results it causes.
    task automatic predict_timers(teq_pkg::req_t req, logic [63:0] now, logic [63:0] exp_at,
                                  logic [31:0] period, logic [31:0] cid);
        bit due [NSLOTS];
        bit sent [NSLOTS];
        int slot;
        int best;
        slot = -1;
        case (req)
            teq_pkg::REQ_SCHEDULE: begin
                for (int i = NSLOTS - 1; i >= 0; i--) if (!tbl_valid[i]) slot = i;
                if (slot < 0) begin
                    expect_event(mk(teq_pkg::EV_SCHEDULED, 0, 0, 0, 0, 1));
                end else begin
                    last_ident++;
                    tbl_valid[slot] = 1; tbl_id[slot] = last_ident;
                    tbl_exp[slot] = exp_at; tbl_per[slot] = period; tbl_set[slot] = now;
                    expect_event(mk(teq_pkg::EV_SCHEDULED, 1, last_ident, 0, 0, 1));
                end
            end
            teq_pkg::REQ_CANCEL: begin
                for (int i = 0; i < NSLOTS; i++)
                    if (slot < 0 && tbl_valid[i] && tbl_id[i] == cid) slot = i;
                if (slot >= 0) tbl_valid[slot] = 0;
                expect_event(mk(teq_pkg::EV_CANCELED, slot >= 0, cid, 0, 0, 1));
            end
            teq_pkg::REQ_TICK: begin
                for (int i = 0; i < NSLOTS; i++) begin
                    due[i] = tbl_valid[i] && tbl_exp[i] <= now;
                    sent[i] = 0;
                end
                forever begin
                    best = -1;
                    for (int i = 0; i < NSLOTS; i++)
                        if (due[i] && !sent[i] && (best < 0 || orders_first(i, best)))
                            best = i;
                    if (best < 0) break;
                    sent[best] = 1;
                    expect_event(mk(teq_pkg::EV_EXPIRED, 1, tbl_id[best],
                                    tbl_exp[best], tbl_set[best], 0));
                end
                // One-shot timers leave the table, periodic ones are rearmed.
                for (int i = 0; i < NSLOTS; i++) begin
                    if (due[i]) begin
                        if (tbl_per[i] == 0) begin
                            tbl_valid[i] = 0;
                        end else begin
                            tbl_exp[i] = tbl_exp[i] + 64'(tbl_per[i]);
                            tbl_set[i] = now;
                        end
                    end
                end
                expect_event(mk(teq_pkg::EV_DONE, 1, 0, 0, 0, 1));
            end
            default: begin
            end
        endcase
    endtask

    // Send one request transaction, then predict its results. Valid stays high
    // afterwards unless the next request is preceded by idle cycles.
    task automatic send_request(teq_pkg::req_t req, logic [63:0] now, logic [63:0] exp_at,
                                logic [31:0] period, logic [31:0] cid);
        int idle;
        idle = 0;
        while ($urandom_range(99) < send_idle_pct) idle++;
        if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_now_time <= now;
        s_expire_at <= exp_at;
        s_repeat_interval <= period;
        s_cancel_id <= cid;
        do @(posedge aclk); while (!s_ready);
        predict_timers(req, now, exp_at, period, cid);
    endtask

    // Wait, with the input idle, until every expected result has come.
    task automatic drain_results();
        if (pending_events.size() != 0) begin
            s_valid <= 1'b0;
            while (pending_events.size() != 0) @(posedge aclk);
        end
    endtask

    // Receiver: random stalls, plus a long hold-off counted here on request.
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result check against the oldest expectation.
    always @(posedge aclk) begin
        event_rec_t want;
        event_rec_t got;
        if (aresetn && m_valid && m_ready) begin
            got = mk(m_event_kind, m_ok, m_timer_ident, m_expiry_time, m_set_time, m_last);
            events_seen++;
            if (m_event_kind == teq_pkg::EV_EXPIRED) expiries_seen++;
            if (pending_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected transaction: %p", got);
            end else begin
                want = pending_events.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, actual %p", want, got);
                end
            end
        end
    end

    // Timeout watchdog.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Random request mostly within a small window of time so timers do fire.
    task automatic random_request(ref logic [63:0] clock_now);
        int pick;
        logic [63:0] t;
        logic [31:0] p;
        pick = $urandom_range(99);
        clock_now = clock_now + 64'($urandom_range(60));
        t = clock_now + 64'($urandom_range(150));
        p = ($urandom_range(2) == 0) ? 32'd0 : 32'($urandom_range(1, 120));
        if ($urandom_range(19) == 0) begin
            t = {$urandom, $urandom};
            p = $urandom;
        end
        if (pick < 45)
            send_request(teq_pkg::REQ_SCHEDULE, clock_now, t, p, $urandom);
        else if (pick < 60)
            send_request(teq_pkg::REQ_CANCEL, clock_now, t, p,
                         ($urandom_range(3) == 0) ? $urandom
                                                  : last_ident - 32'($urandom_range(5)));
        else if (pick < 97)
            send_request(teq_pkg::REQ_TICK, clock_now, t, p, $urandom);
        else
            send_request(teq_pkg::REQ_NONE, {$urandom, $urandom}, t, p, $urandom);
    endtask

    stim_row_t rows[$];

    function automatic stim_row_t row(teq_pkg::req_t r, logic [63:0] n, logic [63:0] e,
                                      logic [31:0] p, logic [31:0] c, bit ty,
                                      event_rec_t f);
        stim_row_t s;
        s.req = r; s.now = n; s.exp_at = e; s.period = p; s.cid = c;
        s.typed = ty; s.first = f;
        return s;
    endfunction

    initial begin
        logic [63:0] clock_now;
        event_rec_t none;
        int random_items;
        none = '0;
        foreach (tbl_valid[i]) tbl_valid[i] = 0;
        last_ident = 0;

        // Directed table: extremes, every request kind and the special cases.
        rows.insert(rows.size(), row(teq_pkg::REQ_TICK, '1, 0, 0, 0, 1,
                                     mk(teq_pkg::EV_DONE, 1, 0, 0, 0, 1)));
        rows.insert(rows.size(), row(teq_pkg::REQ_CANCEL, 0, 0, 0, '1, 1,
                                     mk(teq_pkg::EV_CANCELED, 0, '1, 0, 0, 1)));
        rows.insert(rows.size(), row(teq_pkg::REQ_SCHEDULE, 0, '1, '1, 0, 1,
                                     mk(teq_pkg::EV_SCHEDULED, 1, 1, 0, 0, 1)));
        rows.insert(rows.size(), row(teq_pkg::REQ_SCHEDULE, 5, 10, 0, 0, 1,
                                     mk(teq_pkg::EV_SCHEDULED, 1, 2, 0, 0, 1)));
        rows.insert(rows.size(), row(teq_pkg::REQ_SCHEDULE, 5, 10, 3, 0, 0, none));
        rows.insert(rows.size(), row(teq_pkg::REQ_SCHEDULE, 6, 0, 1, 0, 0, none));
        rows.insert(rows.size(), row(teq_pkg::REQ_NONE, '1, '1, '1, '1, 0, none));
        // A timer rearmed by a tick is reported once only.
        rows.insert(rows.size(), row(teq_pkg::REQ_TICK, 100, 0, 0, 0, 0, none));
        rows.insert(rows.size(), row(teq_pkg::REQ_CANCEL, 0, 0, 0, 2, 1,
                                     mk(teq_pkg::EV_CANCELED, 0, 2, 0, 0, 1)));
        rows.insert(rows.size(), row(teq_pkg::REQ_CANCEL, 0, 0, 0, 3, 1,
                                     mk(teq_pkg::EV_CANCELED, 1, 3, 0, 0, 1)));
        // The expiry sum wraps here.
        rows.insert(rows.size(), row(teq_pkg::REQ_TICK, '1, 0, 0, 0, 0, none));
        for (int i = 0; i < 16; i++)
            rows.insert(rows.size(), row(teq_pkg::REQ_SCHEDULE, 7, 64'(i % 3), 0, 0, 0, none));
        rows.insert(rows.size(), row(teq_pkg::REQ_TICK, 2, 0, 0, 0, 0, none));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[k]) begin
            if (rows[k].typed) begin
                drain_results();
            end
            send_request(rows[k].req, rows[k].now, rows[k].exp_at,
                         rows[k].period, rows[k].cid);
            if (rows[k].typed && pending_events[pending_events.size() - 1] != rows[k].first) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Predictor disagrees with table row %0d", k);
            end
        end

        // Fill the table while the receiver holds off so the input stalls.
        drain_results();
        hold_off = 400;
        for (int i = 0; i < 20; i++)
            send_request(teq_pkg::REQ_SCHEDULE, 1000, 64'(1000 + i), 32'(i % 2), 0);
        send_request(teq_pkg::REQ_TICK, 2000, 0, 0, 0);
        drain_results();   // sender pauses until every result has come

        clock_now = 3000;
        random_items = 0;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 50 : 0;
            recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 20 : 0;
            for (int i = 0; i < 27; i++) begin
                random_request(clock_now);
                random_items++;
            end
        end

        drain_results();
        s_valid <= 1'b0;
        repeat (200) @(posedge aclk);
        $display("Ran %0d directed and %0d random requests; %0d results, %0d expiries.",
                 rows.size() + 21, random_items, events_seen, expiries_seen);
        if (mismatches == 0 && pending_events.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
